>>> hw/rtl/bmp_row_pixel_decoder_defines.svh
// Assertion macros used by the checker file.
`ifndef BMP_ROW_PIXEL_DECODER_DEFINES_SVH
`define BMP_ROW_PIXEL_DECODER_DEFINES_SVH

// Same-cycle implication.
`define BMPRD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BMPRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/bmprd_pkg.sv
package bmprd_pkg;

   localparam int DEPTH_CODE_W = 3;
   localparam int DIM_W        = 12;
   localparam int PIX_XY_W     = 11;
   localparam int RGB_W        = 24;
   localparam int BYTE_W       = 8;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 12;
   localparam int COUNT_W      = 3;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_DEPTH_CODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

   localparam logic [DEPTH_CODE_W-1:0] DEPTH_1BPP  = 3'd0;
   localparam logic [DEPTH_CODE_W-1:0] DEPTH_4BPP  = 3'd1;
   localparam logic [DEPTH_CODE_W-1:0] DEPTH_8BPP  = 3'd2;
   localparam logic [DEPTH_CODE_W-1:0] DEPTH_16BPP = 3'd3;
   localparam logic [DEPTH_CODE_W-1:0] DEPTH_24BPP = 3'd4;

   localparam logic [DEPTH_CODE_W-1:0] DEPTH_RESET = DEPTH_8BPP;
   localparam logic [DIM_W-1:0]        DIM_RESET   = 12'd1;

   localparam logic REQ_PALETTE = 1'b0;
   localparam logic REQ_PIXEL   = 1'b1;

   typedef enum logic [1:0] {
      MODE_BIT1,
      MODE_NIBBLE,
      MODE_BYTE,
      MODE_DIRECT
   } pix_mode_type;

   typedef enum logic {
      ENTRY_PAL_WRITE,
      ENTRY_PIXELS
   } entry_kind_type;

   typedef struct packed {
      entry_kind_type        kind;
      pix_mode_type          mode;
      logic [BYTE_W-1:0]     code;
      logic [RGB_W-1:0]      rgb;
      logic [COUNT_W-1:0]    count_m1;
      logic [PIX_XY_W-1:0]   x;
      logic [PIX_XY_W-1:0]   y;
      logic                  done;
   } queue_entry_type;

endpackage

>>> hw/rtl/bmprd_req_if.sv
interface bmprd_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [bmprd_pkg::BYTE_W-1:0]  palette_index;
   logic [bmprd_pkg::RGB_W-1:0]   palette_rgb;
   logic [bmprd_pkg::BYTE_W-1:0]  data_byte;

   modport source (output valid, output req_type, output palette_index,
                   output palette_rgb, output data_byte, input ready);
   modport sink (input valid, input req_type, input palette_index,
                 input palette_rgb, input data_byte, output ready);
endinterface

>>> hw/rtl/bmprd_rsp_if.sv
interface bmprd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bmprd_pkg::PIX_XY_W-1:0]  pixel_x;
   logic [bmprd_pkg::PIX_XY_W-1:0]  pixel_y;
   logic [bmprd_pkg::RGB_W-1:0]     pixel_rgb;
   logic                            last_of_run;
   logic                            image_done;

   modport source (output valid, output pixel_x, output pixel_y, output pixel_rgb,
                   output last_of_run, output image_done, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, input pixel_rgb,
                 input last_of_run, input image_done, output ready);
endinterface

>>> hw/rtl/bmprd_csr_if.sv
interface bmprd_csr_if;
   logic                               valid;
   logic                               ready;
   logic [bmprd_pkg::CSR_INDEX_W-1:0]  index;
   logic [bmprd_pkg::CSR_DATA_W-1:0]   wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> hw/rtl/bmprd_front.sv
module bmprd_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                         clock,
   input  logic                         reset,
   bmprd_req_if.sink                    req_chan,
   bmprd_csr_if.sink                    csr_chan,
   output logic                         push_valid,
   output bmprd_pkg::queue_entry_type   push_entry,
   input  logic                         queue_full
);
   import bmprd_pkg::*;

   localparam int WW            = $clog2(MAX_WIDTH + 1);
   localparam int HW            = $clog2(MAX_HEIGHT + 1);
   localparam int ROWW          = $clog2(MAX_HEIGHT);
   localparam int WCMP          = (WW > DIM_W) ? WW : DIM_W;
   localparam int HCMP          = (HW > DIM_W) ? HW : DIM_W;
   localparam int BITS_W        = $clog2(MAX_WIDTH * 24 + 32) + 1;
   localparam int MAX_ROW_BYTES = ((MAX_WIDTH * 24 + 31) / 32) * 4;
   localparam int RBW           = $clog2(MAX_ROW_BYTES);
   localparam int PW            = 16;

   localparam logic [1:0] PHASE_0 = 2'd0;
   localparam logic [1:0] PHASE_1 = 2'd1;
   localparam logic [1:0] PHASE_2 = 2'd2;

   function automatic logic [7:0] widen5(input logic [4:0] v);
      widen5 = {v, v[4:2]};
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] v);
      widen6 = {v, v[5:4]};
   endfunction

   logic [DEPTH_CODE_W-1:0] depth_ff, depth_in;
   logic [DIM_W-1:0]        width_ff, width_in;
   logic [DIM_W-1:0]        height_ff, height_in;
   logic [RBW-1:0]          row_byte_ff, row_byte_in;
   logic [WW-1:0]           col_ff, col_in;
   logic [ROWW-1:0]         frow_ff, frow_in;
   logic [PW-1:0]           partial_ff, partial_in;
   logic [1:0]              phase_ff, phase_in;

   logic                    accept;
   logic                    cfg_write;
   logic [WW-1:0]           w;
   logic [HW-1:0]           h;
   logic [BITS_W-1:0]       w_ext;
   logic [BITS_W-1:0]       bits;
   logic [BITS_W-1:0]       row_bytes;
   logic                    row_end;
   logic                    depth_ok;
   logic                    col_live;
   logic [WW-1:0]           avail;
   logic [COUNT_W:0]        n;
   logic [WW-1:0]           col_sum;
   logic                    last_row;
   logic                    done;
   logic [HW-1:0]           y_full;
   logic [15:0]             raw565;
   logic [RGB_W-1:0]        direct_rgb;
   pix_mode_type            mode;
   logic [BYTE_W-1:0]       b;

   assign accept          = req_chan.valid && req_chan.ready;
   assign req_chan.ready  = !queue_full;
   assign csr_chan.ready  = 1'b1;
   assign cfg_write       = csr_chan.valid && csr_chan.ready;
   assign b               = req_chan.data_byte;

   always_comb begin
      depth_in  = depth_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (cfg_write) begin
         case (csr_chan.index)
            REG_DEPTH_CODE: begin
               depth_in = csr_chan.wdata[DEPTH_CODE_W-1:0];
            end
            REG_IMAGE_WIDTH: begin
               width_in = csr_chan.wdata[DIM_W-1:0];
            end
            REG_IMAGE_HEIGHT: begin
               height_in = csr_chan.wdata[DIM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w = WW'(1);
      end else if (WCMP'(width_ff) > WCMP'(MAX_WIDTH)) begin
         w = WW'(MAX_WIDTH);
      end else begin
         w = WW'(width_ff);
      end
      if (height_ff == '0) begin
         h = HW'(1);
      end else if (HCMP'(height_ff) > HCMP'(MAX_HEIGHT)) begin
         h = HW'(MAX_HEIGHT);
      end else begin
         h = HW'(height_ff);
      end
   end

   always_comb begin
      w_ext = BITS_W'(w);
      case (depth_ff)
         DEPTH_1BPP:  bits = w_ext;
         DEPTH_4BPP:  bits = w_ext << 2;
         DEPTH_8BPP:  bits = w_ext << 3;
         DEPTH_16BPP: bits = w_ext << 4;
         DEPTH_24BPP: bits = (w_ext << 4) + (w_ext << 3);
         default:     bits = '0;
      endcase
      row_bytes = ((bits + BITS_W'(31)) >> 5) << 2;
      row_end   = (BITS_W'(row_byte_ff) + BITS_W'(1)) >= row_bytes;
   end

   always_comb begin
      depth_ok = depth_ff <= DEPTH_24BPP;
      col_live = col_ff < w;
      avail    = w - col_ff;
      raw565   = {b, partial_ff[7:0]};
      case (depth_ff)
         DEPTH_1BPP: begin
            n    = (avail >= WW'(8)) ? (COUNT_W+1)'(8) : (COUNT_W+1)'(avail);
            mode = MODE_BIT1;
         end
         DEPTH_4BPP: begin
            n    = (avail >= WW'(2)) ? (COUNT_W+1)'(2) : (COUNT_W+1)'(1);
            mode = MODE_NIBBLE;
         end
         DEPTH_8BPP: begin
            n    = (COUNT_W+1)'(1);
            mode = MODE_BYTE;
         end
         DEPTH_16BPP: begin
            n    = (phase_ff == PHASE_0) ? '0 : (COUNT_W+1)'(1);
            mode = MODE_DIRECT;
         end
         DEPTH_24BPP: begin
            n    = (phase_ff == PHASE_0 || phase_ff == PHASE_1) ? '0 : (COUNT_W+1)'(1);
            mode = MODE_DIRECT;
         end
         default: begin
            n    = '0;
            mode = MODE_BYTE;
         end
      endcase
      if (depth_ff == DEPTH_16BPP) begin
         direct_rgb = {widen5(raw565[15:11]), widen6(raw565[10:5]), widen5(raw565[4:0])};
      end else begin
         direct_rgb = {b, partial_ff};
      end
      col_sum  = col_ff + WW'(n);
      last_row = ((HW+1)'(frow_ff) + (HW+1)'(1)) >= (HW+1)'(h);
      done     = (col_sum == w) && last_row;
      if (HW'(frow_ff) < h) begin
         y_full = h - HW'(1) - HW'(frow_ff);
      end else begin
         y_full = '0;
      end
   end

   always_comb begin
      row_byte_in = row_byte_ff;
      col_in      = col_ff;
      frow_in     = frow_ff;
      partial_in  = partial_ff;
      phase_in    = phase_ff;
      if (accept && req_chan.req_type == REQ_PIXEL && depth_ok) begin
         if (col_live) begin
            col_in = col_sum;
            case (depth_ff)
               DEPTH_16BPP: begin
                  if (phase_ff == PHASE_0) begin
                     partial_in = PW'(b);
                     phase_in   = PHASE_1;
                  end else begin
                     phase_in = PHASE_0;
                  end
               end
               DEPTH_24BPP: begin
                  if (phase_ff == PHASE_0) begin
                     partial_in = PW'(b);
                     phase_in   = PHASE_1;
                  end else if (phase_ff == PHASE_1) begin
                     partial_in = {b, partial_ff[7:0]};
                     phase_in   = PHASE_2;
                  end else begin
                     phase_in = PHASE_0;
                  end
               end
               default: begin
               end
            endcase
         end
         if (row_end) begin
            row_byte_in = '0;
            col_in      = '0;
            phase_in    = PHASE_0;
            partial_in  = '0;
            frow_in     = last_row ? '0 : frow_ff + ROWW'(1);
         end else begin
            row_byte_in = row_byte_ff + RBW'(1);
         end
      end
   end

   always_comb begin
      push_valid = accept && (req_chan.req_type == REQ_PALETTE ||
                              (depth_ok && col_live && n != '0));
      if (req_chan.req_type == REQ_PALETTE) begin
         push_entry.kind = ENTRY_PAL_WRITE;
         push_entry.code = req_chan.palette_index;
         push_entry.rgb  = req_chan.palette_rgb;
      end else begin
         push_entry.kind = ENTRY_PIXELS;
         push_entry.code = b;
         push_entry.rgb  = direct_rgb;
      end
      push_entry.mode     = mode;
      push_entry.count_m1 = COUNT_W'(n - (COUNT_W+1)'(1));
      push_entry.x        = PIX_XY_W'(col_ff);
      push_entry.y        = PIX_XY_W'(y_full);
      push_entry.done     = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff    <= DEPTH_RESET;
         width_ff    <= DIM_RESET;
         height_ff   <= DIM_RESET;
         row_byte_ff <= '0;
         col_ff      <= '0;
         frow_ff     <= '0;
         partial_ff  <= '0;
         phase_ff    <= PHASE_0;
      end else begin
         depth_ff    <= depth_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         row_byte_ff <= row_byte_in;
         col_ff      <= col_in;
         frow_ff     <= frow_in;
         partial_ff  <= partial_in;
         phase_ff    <= phase_in;
      end
   end

endmodule

>>> hw/rtl/bmprd_queue.sv
module bmprd_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   input  bmprd_pkg::queue_entry_type   push_entry,
   output logic                         full,
   output logic                         head_valid,
   output bmprd_pkg::queue_entry_type   head_entry,
   input  logic                         pop
);
   import bmprd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type     entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push;

   assign full       = count_ff == CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hw/rtl/bmprd_back.sv
module bmprd_back #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  bmprd_pkg::queue_entry_type   head_entry,
   output logic                         pop,
   bmprd_rsp_if.source                  rsp_chan
);
   import bmprd_pkg::*;

   localparam int PW    = $clog2(PALETTE_ENTRIES);
   localparam int IDX_W = BYTE_W + 1;

   logic [RGB_W-1:0]    pal_mem [PALETTE_ENTRIES];
   logic [RGB_W-1:0]    rd_ff;

   logic [COUNT_W-1:0]  k_ff, k_in;
   logic                out_valid_ff, out_valid_in;
   logic [PIX_XY_W-1:0] x_ff;
   logic [PIX_XY_W-1:0] y_ff;
   logic [RGB_W-1:0]    direct_ff;
   logic                pal_sel_ff;
   logic                blank_ff;
   logic                last_ff;
   logic                done_ff;

   logic                advance;
   logic                is_write;
   logic                issue;
   logic                last_px;
   logic                use_pal;
   logic                idx_ok;
   logic                wr_ok;
   logic [BYTE_W-1:0]   pal_idx;

   always_comb begin
      advance  = !out_valid_ff || rsp_chan.ready;
      is_write = head_valid && head_entry.kind == ENTRY_PAL_WRITE;
      issue    = head_valid && head_entry.kind == ENTRY_PIXELS && advance;
      last_px  = k_ff == head_entry.count_m1;
      pop      = is_write || (issue && last_px);
      use_pal  = head_entry.mode != MODE_DIRECT;
      case (head_entry.mode)
         MODE_BIT1: begin
            pal_idx = {{(BYTE_W-1){1'b0}}, head_entry.code[~k_ff]};
         end
         MODE_NIBBLE: begin
            pal_idx = k_ff[0] ? {4'b0000, head_entry.code[3:0]}
                              : {4'b0000, head_entry.code[7:4]};
         end
         default: begin
            pal_idx = head_entry.code;
         end
      endcase
      idx_ok = {1'b0, pal_idx} < IDX_W'(PALETTE_ENTRIES);
      wr_ok  = {1'b0, head_entry.code} < IDX_W'(PALETTE_ENTRIES);
      k_in   = k_ff;
      if (issue) begin
         k_in = last_px ? '0 : k_ff + COUNT_W'(1);
      end
      out_valid_in = advance ? issue : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (is_write && wr_ok) begin
         pal_mem[head_entry.code[PW-1:0]] <= head_entry.rgb;
      end
      if (issue && use_pal && idx_ok) begin
         rd_ff <= pal_mem[pal_idx[PW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         x_ff       <= head_entry.x + PIX_XY_W'(k_ff);
         y_ff       <= head_entry.y;
         direct_ff  <= head_entry.rgb;
         pal_sel_ff <= use_pal;
         blank_ff   <= use_pal && !idx_ok;
         last_ff    <= last_px;
         done_ff    <= head_entry.done && last_px;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.pixel_x     = x_ff;
   assign rsp_chan.pixel_y     = y_ff;
   assign rsp_chan.pixel_rgb   = blank_ff ? '0 : (pal_sel_ff ? rd_ff : direct_ff);
   assign rsp_chan.last_of_run = last_ff;
   assign rsp_chan.image_done  = done_ff;

endmodule

>>> hw/rtl/bmp_row_pixel_decoder.sv
// Channel   Dir  Handshake     Carries
// req_chan  in   valid/ready   palette load or one pixel-array byte
// rsp_chan  out  valid/ready   one RGB888 pixel with x, y and run/image flags
// csr_chan  in   valid/ready   register index and write data, always ready
//
// A byte is taken every cycle while the four-entry queue has room.
// Results leave one per cycle from the palette read stage while rsp_chan is
// ready; a 1 bpp byte yields up to 8 pixels, 4 bpp up to 2, other depths 1 or 0.
// A byte's first pixel passes through the queue, then the output register.
// Reset is synchronous; the palette is not cleared and needs loading.
// A stalled rsp_chan holds its pixel; the queue then fills and drops req ready.
module bmp_row_pixel_decoder #(
   parameter int MAX_WIDTH       = 2048,
   parameter int MAX_HEIGHT      = 2048,
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic          clock,
   input  logic          reset,
   bmprd_req_if.sink     req_chan,
   bmprd_rsp_if.source   rsp_chan,
   bmprd_csr_if.sink     csr_chan
);
   import bmprd_pkg::*;

   logic            push_valid;
   queue_entry_type push_entry;
   logic            queue_full;
   logic            head_valid;
   queue_entry_type head_entry;
   logic            pop;

   bmprd_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   bmprd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   bmprd_back #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

>>> hw/rtl/bmprd_checker.sv
`include "bmp_row_pixel_decoder_defines.svh"

module bmprd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [bmprd_pkg::PIX_XY_W-1:0]  pixel_x,
   input logic [bmprd_pkg::PIX_XY_W-1:0]  pixel_y,
   input logic [bmprd_pkg::RGB_W-1:0]     pixel_rgb,
   input logic                            last_of_run,
   input logic                            image_done
);

   `BMPRD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_rgb) && $stable(last_of_run) && $stable(image_done), "stalled pixel changed")

   `BMPRD_ASSERT_NOW(a_done_ends_run, clock, reset, rsp_valid && image_done, last_of_run, "image end not on the last pixel of its byte")

   `BMPRD_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid, "pixel shown right after reset")

   `BMPRD_ASSERT_NEXT(a_run_steps, clock, reset, rsp_valid && rsp_ready && !last_of_run, rsp_valid && (pixel_x == ($past(pixel_x) + 1'b1)) && $stable(pixel_y), "pixel run broken")

endmodule

bind bmp_row_pixel_decoder bmprd_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .pixel_x     (rsp_chan.pixel_x),
   .pixel_y     (rsp_chan.pixel_y),
   .pixel_rgb   (rsp_chan.pixel_rgb),
   .last_of_run (rsp_chan.last_of_run),
   .image_done  (rsp_chan.image_done)
);

>>> verif/bmp_row_pixel_decoder_tb.sv
`timescale 1ns / 1ps

module bmp_row_pixel_decoder_tb;
   import bmprd_pkg::*;

   localparam int IMG_MAX_W = 2048;
   localparam int IMG_MAX_H = 2048;
   localparam int PAL_SLOTS = 256;
   localparam int RANDOM_ITEMS = 446;
   localparam int DRAIN_CYCLES = 48;
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_PIXELS_PER_BYTE = 8;
   localparam logic [DEPTH_CODE_W-1:0] DEPTH_CODE_TOP = '1;

   typedef struct packed {
      logic                kind;
      logic [BYTE_W-1:0]   slot;
      logic [RGB_W-1:0]    color;
      logic [BYTE_W-1:0]   data;
   } bmp_req_type;

   typedef struct packed {
      logic [PIX_XY_W-1:0] x;
      logic [PIX_XY_W-1:0] y;
      logic [RGB_W-1:0]    rgb;
      logic                run_end;
      logic                done;
   } pixel_type;

   logic clock = 1'b0;
   logic reset;

   bmprd_req_if req_chan ();
   bmprd_rsp_if rsp_chan ();
   bmprd_csr_if csr_chan ();

   bmp_row_pixel_decoder #(
      .MAX_WIDTH(IMG_MAX_W),
      .MAX_HEIGHT(IMG_MAX_H),
      .PALETTE_ENTRIES(PAL_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // decoder shadow: registers, palette and counters
   logic [DEPTH_CODE_W-1:0] depth_reg;
   logic [DIM_W-1:0]        width_reg;
   logic [DIM_W-1:0]        height_reg;
   logic [RGB_W-1:0]        palette_shadow [PAL_SLOTS];
   logic [12:0]             row_byte_no;
   logic [11:0]             col_count;
   logic [10:0]             file_row;
   logic [15:0]             partial_px;
   logic [1:0]              byte_phase;

   pixel_type   burst [$];
   pixel_type   pixels_due [$];
   bmp_req_type req_backlog [$];
   bmp_req_type in_flight;

   logic [PAL_SLOTS-1:0]    slot_loaded = '0;
   logic [BYTE_W-1:0]       loaded_slots [$];
   logic [DEPTH_CODE_W-1:0] plan_depth;

   int  fault_count = 0;
   int  stall_cycles;
   int  cycle_no;
   logic calm;

   assign calm = (cycle_no >= 1500) && (cycle_no < 2500);

   function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned row_length(input logic [DEPTH_CODE_W-1:0] d,
                                              input int unsigned w);
      int unsigned bpp;
      case (d)
         DEPTH_1BPP:  bpp = 1;
         DEPTH_4BPP:  bpp = 4;
         DEPTH_8BPP:  bpp = 8;
         DEPTH_16BPP: bpp = 16;
         default:     bpp = 24;
      endcase
      return ((w * bpp + 31) / 32) * 4;
   endfunction

   function automatic logic [7:0] widen5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   function automatic void emit_pixel(input logic [RGB_W-1:0] rgb, input int unsigned w,
                                      input int unsigned h);
      pixel_type p;
      if (col_count >= w || burst.size() >= MAX_PIXELS_PER_BYTE) return;
      p.x = col_count[PIX_XY_W-1:0];
      col_count = col_count + 1'b1;
      p.y = (file_row < h) ? PIX_XY_W'(h - 1 - file_row) : '0;
      p.rgb = rgb;
      p.run_end = 1'b0;
      p.done = (col_count == w) && (file_row + 1 >= h);
      burst.push_back(p);
   endfunction

   function automatic void set_reg(input logic [CSR_INDEX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] val);
      case (idx)
         REG_DEPTH_CODE:   depth_reg = val[DEPTH_CODE_W-1:0];
         REG_IMAGE_WIDTH:  width_reg = val;
         REG_IMAGE_HEIGHT: height_reg = val;
         default: ;
      endcase
   endfunction

   function automatic void decode_byte(input bmp_req_type it);
      int unsigned w, h, row_len;
      logic [15:0] raw;
      if (it.kind == REQ_PALETTE) begin
         palette_shadow[it.slot] = it.color;
         return;
      end
      if (depth_reg > DEPTH_24BPP) return;
      w = clamp_dim(width_reg, IMG_MAX_W);
      h = clamp_dim(height_reg, IMG_MAX_H);
      row_len = row_length(depth_reg, w);
      burst.delete();
      if (col_count < w) begin
         case (depth_reg)
            DEPTH_1BPP: begin
               for (int i = 7; i >= 0; i--) emit_pixel(palette_shadow[it.data[i]], w, h);
            end
            DEPTH_4BPP: begin
               emit_pixel(palette_shadow[it.data[7:4]], w, h);
               emit_pixel(palette_shadow[it.data[3:0]], w, h);
            end
            DEPTH_8BPP: begin
               emit_pixel(palette_shadow[it.data], w, h);
            end
            DEPTH_16BPP: begin
               if (byte_phase == 2'd0) begin
                  partial_px = {8'h00, it.data};
                  byte_phase = 2'd1;
               end else begin
                  raw = {it.data, partial_px[7:0]};
                  byte_phase = 2'd0;
                  emit_pixel({widen5(raw[15:11]), widen6(raw[10:5]), widen5(raw[4:0])}, w, h);
               end
            end
            default: begin
               if (byte_phase == 2'd0) begin
                  partial_px = {8'h00, it.data};
                  byte_phase = 2'd1;
               end else if (byte_phase == 2'd1) begin
                  partial_px = {it.data, partial_px[7:0]};
                  byte_phase = 2'd2;
               end else begin
                  byte_phase = 2'd0;
                  emit_pixel({it.data, partial_px}, w, h);
               end
            end
         endcase
      end
      // row end: clear column state, advance or wrap the file row
      if (row_byte_no + 1 >= row_len) begin
         row_byte_no = '0;
         col_count = '0;
         byte_phase = '0;
         partial_px = '0;
         if (file_row + 1 >= h) file_row = '0;
         else file_row = file_row + 1'b1;
      end else begin
         row_byte_no = row_byte_no + 1'b1;
      end
      if (burst.size() != 0) begin
         burst[burst.size() - 1].run_end = 1'b1;
         foreach (burst[k]) pixels_due.push_back(burst[k]);
      end
   endfunction

   function automatic void check_pixel();
      pixel_type got, want;
      got = {rsp_chan.pixel_x, rsp_chan.pixel_y, rsp_chan.pixel_rgb,
             rsp_chan.last_of_run, rsp_chan.image_done};
      if (pixels_due.size() == 0) begin
         fault_count++;
         if (fault_count <= 10)
            $display("unexpected pixel x=%0d y=%0d rgb=%06h last=%0b done=%0b",
                     got.x, got.y, got.rgb, got.run_end, got.done);
         return;
      end
      want = pixels_due.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.rgb !== want.rgb ||
          got.run_end !== want.run_end || got.done !== want.done) begin
         fault_count++;
         if (fault_count <= 10)
            $display("pixel mismatch: expected x=%0d y=%0d rgb=%06h last=%0b done=%0b, got x=%0d y=%0d rgb=%06h last=%0b done=%0b",
                     want.x, want.y, want.rgb, want.run_end, want.done,
                     got.x, got.y, got.rgb, got.run_end, got.done);
      end
   endfunction

   // driver: feed items from the backlog, predict each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         depth_reg = DEPTH_RESET;
         width_reg = DIM_RESET;
         height_reg = DIM_RESET;
         row_byte_no = '0;
         col_count = '0;
         file_row = '0;
         partial_px = '0;
         byte_phase = '0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) set_reg(csr_chan.index, csr_chan.wdata);
         if (req_chan.valid && req_chan.ready) decode_byte(in_flight);
         if (!req_chan.valid || req_chan.ready) begin
            if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= 27)) begin
               in_flight = req_backlog.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.req_type <= in_flight.kind;
               req_chan.palette_index <= in_flight.slot;
               req_chan.palette_rgb <= in_flight.color;
               req_chan.data_byte <= in_flight.data;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: stall at random, check every accepted pixel
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) check_pixel();
         rsp_chan.ready <= calm || ($urandom_range(99) >= 27);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
         cycle_no <= 0;
      end else begin
         cycle_no <= cycle_no + 1;
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("** bmp_row_pixel_decoder: FAILED **");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.wdata <= val;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic configure(input logic [DEPTH_CODE_W-1:0] d, input logic [DIM_W-1:0] w,
                            input logic [DIM_W-1:0] h);
      write_reg(REG_DEPTH_CODE, CSR_DATA_W'(d));
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
      plan_depth = d;
   endtask

   task automatic push_load(input logic [BYTE_W-1:0] slot, input logic [RGB_W-1:0] color);
      bmp_req_type it;
      it.kind = REQ_PALETTE;
      it.slot = slot;
      it.color = color;
      it.data = BYTE_W'($urandom_range(255));
      req_backlog.push_back(it);
      if (!slot_loaded[slot]) begin
         slot_loaded[slot] = 1'b1;
         loaded_slots.push_back(slot);
      end
   endtask

   task automatic push_byte(input logic [BYTE_W-1:0] b);
      bmp_req_type it;
      it.kind = REQ_PIXEL;
      it.slot = BYTE_W'($urandom_range(255));
      it.color = RGB_W'($urandom);
      // keep 8 bpp reads on loaded palette slots
      if (plan_depth == DEPTH_8BPP && !slot_loaded[b])
         b = loaded_slots[$urandom_range(loaded_slots.size() - 1)];
      it.data = b;
      req_backlog.push_back(it);
   endtask

   task automatic settle();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_chan.valid || pixels_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned planned, n, img, r;
      logic [DEPTH_CODE_W-1:0] d;
      logic [DIM_W-1:0] w, h;
      req_chan.valid = 1'b0;
      req_chan.req_type = REQ_PALETTE;
      req_chan.palette_index = '0;
      req_chan.palette_rgb = '0;
      req_chan.data_byte = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = REG_DEPTH_CODE;
      csr_chan.wdata = '0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      plan_depth = DEPTH_RESET;

      push_load(8'd0, 24'h000000);
      for (int s = 1; s < 15; s++) push_load(BYTE_W'(s), RGB_W'($urandom));
      push_load(8'd15, 24'hFFFFFF);
      push_load(8'd255, RGB_W'($urandom));
      push_byte(8'h0F);
      push_byte(8'hFF);
      push_byte(8'h00);
      push_byte(8'h80);
      settle();
      configure(DEPTH_CODE_TOP, 12'd5, 12'd3);
      push_byte(8'hAA);
      settle();
      configure(DEPTH_16BPP, 12'hFFF, 12'h000);
      push_byte(8'hFF);
      push_byte(8'hFF);
      settle();

      planned = 0;
      while (planned < RANDOM_ITEMS) begin
         r = $urandom_range(99);
         if (r < 6) d = DEPTH_CODE_W'($urandom_range(DEPTH_CODE_TOP, DEPTH_24BPP + 1));
         else d = DEPTH_CODE_W'($urandom_range(DEPTH_24BPP, DEPTH_1BPP));
         r = $urandom_range(99);
         if (r < 3) w = '0;
         else if (r < 6) w = DIM_W'(IMG_MAX_W);
         else if (r < 8) w = '1;
         else w = DIM_W'($urandom_range(12, 1));
         r = $urandom_range(99);
         if (r < 3) h = '0;
         else if (r < 6) h = DIM_W'(IMG_MAX_H);
         else if (r < 8) h = '1;
         else h = DIM_W'($urandom_range(3, 1));
         configure(d, w, h);
         if (d > DEPTH_24BPP) begin
            n = $urandom_range(6, 2);
            for (int k = 0; k < n; k++) push_byte(BYTE_W'($urandom_range(255)));
         end else begin
            img = row_length(d, clamp_dim(w, IMG_MAX_W)) * clamp_dim(h, IMG_MAX_H);
            n = (img <= 64) ? img : $urandom_range(64, 12);
            for (int k = 0; k < n; k++) begin
               if ($urandom_range(99) < 8) begin
                  push_load(BYTE_W'($urandom_range(255)), RGB_W'($urandom));
                  planned++;
               end
               push_byte(BYTE_W'($urandom_range(255)));
               planned++;
            end
         end
         settle();
      end

      if (fault_count == 0) begin
         $display("** bmp_row_pixel_decoder: PASSED **");
      end else begin
         $display("** bmp_row_pixel_decoder: FAILED **");
      end
      $finish;
   end

endmodule
